/* rtl/rotation_between_two_vectors_defines.svh */
// Assertion macros used by the top-level RTL file of the rotation block.
`ifndef ROTATION_BETWEEN_TWO_VECTORS_DEFINES_SVH
`define ROTATION_BETWEEN_TWO_VECTORS_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define RBTV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define RBTV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rbtv_pkg.sv */
package rbtv_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;

  // Internal values are Q.30.
  localparam int ONE_SH = 30;
  localparam int MAG_W  = 32;
  localparam int NORM_W = 64;
  localparam int ROOT_W = 32;
  localparam int QUO_W  = 32;
  localparam int DEN_W  = 33;
  localparam int U_W    = 33;
  localparam int C_W    = 34;
  localparam int R_W    = C_W + 2;
  localparam int ACC_W  = 72;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [5:0][MAG_W-1:0] mag;
    logic [5:0]            neg;
    logic                  degen;
  } norm_tag_t;

  typedef struct packed {
    logic [5:0] neg;
    logic       degen;
  } unit_tag_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] cmag;
    logic [2:0]            cneg;
    logic signed [U_W-1:0] d;
    logic                  degen;
  } cross_tag_t;

  typedef struct packed {
    logic [2:0]            cneg;
    logic [ROOT_W-1:0]     s;
    logic [ROOT_W-1:0]     k;
    logic signed [U_W-1:0] d;
    logic                  degen;
  } axis_tag_t;

  // Round right by sh bits, to nearest with ties away from zero.
  function automatic acc_t rnd_shift(acc_t x, int sh);
    acc_t half;
    acc_t off;
    if (sh == 0) begin
      return x;
    end
    half = acc_t'(1) <<< (sh - 1);
    off  = x[ACC_W-1] ? half - acc_t'(1) : half;
    return (x + off) >>> sh;
  endfunction

  function automatic acc_t abs_acc(acc_t x);
    return x[ACC_W-1] ? -x : x;
  endfunction

  // Left shift that brings the leading one of m up to bit 30.
  function automatic logic [4:0] norm_shift(logic [MAG_W-1:0] m);
    int pos;
    pos = 0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) begin
        pos = i;
      end
    end
    return (pos < ONE_SH) ? 5'(ONE_SH - pos) : 5'd0;
  endfunction

endpackage

/* rtl/rbtv_sqrt.sv */
module rbtv_sqrt #(
  parameter int W     = 64,
  parameter int LANES = 1,
  parameter int TAG_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [LANES-1:0][W-1:0]     in_rad,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][W/2-1:0]   out_root,
  output logic [TAG_W-1:0]            out_tag
);
  localparam int STEPS = W / 2;

  logic                    vld  [STEPS+1];
  logic [LANES-1:0][W-1:0] rem  [STEPS+1];
  logic [LANES-1:0][W-1:0] root [STEPS+1];
  logic [TAG_W-1:0]        tag  [STEPS+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_rad;
  assign root[0] = '0;
  assign tag[0]  = in_tag;

  // One root bit per stage, from one bit pair of the radicand, as in the classic digit-by-digit method.
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * s);
    logic [LANES-1:0][W-1:0] trial;
    logic [LANES-1:0]        take;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = root[s][l] + BIT;
        take[l]  = rem[s][l] >= trial[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      tag[s+1] <= tag[s];
      for (int l = 0; l < LANES; l++) begin
        if (take[l]) begin
          rem[s+1][l]  <= rem[s][l] - trial[l];
          root[s+1][l] <= (root[s][l] >> 1) + BIT;
        end else begin
          rem[s+1][l]  <= rem[s][l];
          root[s+1][l] <= root[s][l] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_tag   = tag[STEPS];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_root[l] = root[STEPS][l][W/2-1:0];
    end
  end

endmodule

/* rtl/rbtv_div.sv */
module rbtv_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int Q_W   = 32,
  parameter int LANES = 1,
  parameter int TAG_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [LANES-1:0][DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][Q_W-1:0]   out_quo,
  output logic [TAG_W-1:0]            out_tag
);
  localparam int WW = DEN_W + Q_W;

  // The quotient must stay below 2^Q_W; one quotient bit per stage.
  logic                        vld [Q_W+1];
  logic [LANES-1:0][WW-1:0]    rem [Q_W+1];
  logic [LANES-1:0][DEN_W-1:0] den [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   quo [Q_W+1];
  logic [TAG_W-1:0]            tag [Q_W+1];

  assign vld[0] = in_valid;
  assign den[0] = in_den;
  assign quo[0] = '0;
  assign tag[0] = in_tag;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = WW'(in_num[l]);
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int BI = Q_W - 1 - s;
    logic [LANES-1:0][WW-1:0] trial;
    logic [LANES-1:0]         take;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = WW'(den[s][l]) << BI;
        take[l]  = rem[s][l] >= trial[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      tag[s+1] <= tag[s];
      den[s+1] <= den[s];
      for (int l = 0; l < LANES; l++) begin
        if (take[l]) begin
          rem[s+1][l] <= rem[s][l] - trial[l];
          quo[s+1][l] <= quo[s][l] | (Q_W'(1) << BI);
        end else begin
          rem[s+1][l] <= rem[s][l];
          quo[s+1][l] <= quo[s][l];
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quo   = quo[Q_W];
  assign out_tag   = tag[Q_W];

endmodule

/* rtl/rotation_between_two_vectors.sv */
// Rotation matrix that turns vector "before" onto vector "after" (Rodrigues form).
// Command channel: drive the six components and raise start for one cycle per word.
// busy is always low, so a new word may be issued in every clock cycle.
// Result channel: done is high for exactly one cycle with the nine entries m00..m22
// in signed Q1.FRAC_BITS and the degenerate flag; the receiver cannot hold it off.
// The pipeline holds two pipelined square roots of 32 stages each and two pipelined
// dividers of 32 stages each, one result bit per stage, plus 22 stages of multiply,
// round and sum. Throughput is one word per cycle.
// Zero vectors or parallel vectors give the identity with degenerate set.
// rst is synchronous and clears all valid bits; words in flight are dropped and
// done stays low until new words reach the end of the pipeline.
`include "rotation_between_two_vectors_defines.svh"

module rotation_between_two_vectors #(
  parameter int IN_WIDTH  = rbtv_pkg::IN_WIDTH_DEF,
  parameter int FRAC_BITS = rbtv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [IN_WIDTH-1:0]  before_x,
  input  logic signed [IN_WIDTH-1:0]  before_y,
  input  logic signed [IN_WIDTH-1:0]  before_z,
  input  logic signed [IN_WIDTH-1:0]  after_x,
  input  logic signed [IN_WIDTH-1:0]  after_y,
  input  logic signed [IN_WIDTH-1:0]  after_z,
  output logic                        done,
  output logic signed [FRAC_BITS+1:0] m00,
  output logic signed [FRAC_BITS+1:0] m01,
  output logic signed [FRAC_BITS+1:0] m02,
  output logic signed [FRAC_BITS+1:0] m10,
  output logic signed [FRAC_BITS+1:0] m11,
  output logic signed [FRAC_BITS+1:0] m12,
  output logic signed [FRAC_BITS+1:0] m20,
  output logic signed [FRAC_BITS+1:0] m21,
  output logic signed [FRAC_BITS+1:0] m22,
  output logic                        degenerate
);
  import rbtv_pkg::*;

  localparam int OUT_W  = FRAC_BITS + 2;
  localparam int OUT_SH = ONE_SH - FRAC_BITS;
  localparam int PW     = 2 * IN_WIDTH;
  localparam logic signed [OUT_W-1:0] ID_OUT  = OUT_W'(1) <<< FRAC_BITS;
  localparam logic signed [OUT_W-1:0] NID_OUT = -ID_OUT;
  localparam logic signed [C_W-1:0]   ONE_C   = C_W'(1) <<< ONE_SH;
  localparam logic signed [C_W-1:0]   NONE_C  = -ONE_C;

  assign busy = 1'b0;

  // ---------------- front: scaling and norms ----------------
  logic                       v1;
  logic signed [IN_WIDTH-1:0] in1 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    in1[0] <= before_x;
    in1[1] <= before_y;
    in1[2] <= before_z;
    in1[3] <= after_x;
    in1[4] <= after_y;
    in1[5] <= after_z;
  end

  logic [MAG_W-1:0]     magc [6];
  logic                 v2;
  logic [MAG_W-1:0]     mag2 [6];
  logic [5:0]           neg2;
  logic [MAG_W-1:0]     or2  [2];
  logic signed [PW-1:0] xp2  [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      magc[i] = MAG_W'(abs_acc(acc_t'(in1[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int i = 0; i < 6; i++) begin
      mag2[i] <= magc[i];
      neg2[i] <= in1[i][IN_WIDTH-1];
    end
    or2[0] <= magc[0] | magc[1] | magc[2];
    or2[1] <= magc[3] | magc[4] | magc[5];
    // Exact integer cross product terms for the parallel test.
    xp2[0] <= in1[1] * in1[5];
    xp2[1] <= in1[2] * in1[4];
    xp2[2] <= in1[2] * in1[3];
    xp2[3] <= in1[0] * in1[5];
    xp2[4] <= in1[0] * in1[4];
    xp2[5] <= in1[1] * in1[3];
  end

  logic             v3;
  logic [MAG_W-1:0] mag3 [6];
  logic [5:0]       neg3;
  logic [4:0]       sh3  [2];
  logic             deg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    mag3   <= mag2;
    neg3   <= neg2;
    sh3[0] <= norm_shift(or2[0]);
    sh3[1] <= norm_shift(or2[1]);
    deg3   <= (or2[0] == '0) || (or2[1] == '0) ||
              ((xp2[0] == xp2[1]) && (xp2[2] == xp2[3]) && (xp2[4] == xp2[5]));
  end

  logic             v4;
  logic [MAG_W-1:0] mag4 [6];
  logic [5:0]       neg4;
  logic             deg4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int i = 0; i < 6; i++) begin
      mag4[i] <= mag3[i] << sh3[i/3];
    end
    neg4 <= neg3;
    deg4 <= deg3;
  end

  logic              v5;
  logic [MAG_W-1:0]  mag5 [6];
  logic [NORM_W-1:0] sq5  [6];
  logic [5:0]        neg5;
  logic              deg5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    for (int i = 0; i < 6; i++) begin
      sq5[i] <= mag4[i] * mag4[i];
    end
    mag5 <= mag4;
    neg5 <= neg4;
    deg5 <= deg4;
  end

  logic                         v6;
  logic [1:0][NORM_W-1:0]       sum6;
  norm_tag_t                    nt6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    sum6[0] <= sq5[0] + sq5[1] + sq5[2];
    sum6[1] <= sq5[3] + sq5[4] + sq5[5];
    for (int i = 0; i < 6; i++) begin
      nt6.mag[i] <= mag5[i];
    end
    nt6.neg   <= neg5;
    nt6.degen <= deg5;
  end

  logic                   nv;
  logic [1:0][ROOT_W-1:0] nroot;
  norm_tag_t              ntag;

  rbtv_sqrt #(
    .W     (NORM_W),
    .LANES (2),
    .TAG_W ($bits(norm_tag_t))
  ) u_norm_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_rad    (sum6),
    .in_tag    (nt6),
    .out_valid (nv),
    .out_root  (nroot),
    .out_tag   (ntag)
  );

  // Unit vectors: round(c * 2^30 / N) = (2|c|2^30 + N) / (2N).
  logic                   gv;
  logic [5:0][NORM_W-1:0] gnum;
  logic [5:0][DEN_W-1:0]  gden;
  unit_tag_t              gtag;

  always_ff @(posedge clk) begin
    if (rst) begin
      gv <= 1'b0;
    end else begin
      gv <= nv;
    end
    for (int i = 0; i < 6; i++) begin
      gnum[i] <= (NORM_W'(ntag.mag[i]) << (ONE_SH + 1)) + NORM_W'(nroot[i/3]);
      gden[i] <= {nroot[i/3], 1'b0};
    end
    gtag.neg   <= ntag.neg;
    gtag.degen <= ntag.degen;
  end

  logic                  uv_valid;
  logic [5:0][QUO_W-1:0] uquo;
  unit_tag_t             utag;

  rbtv_div #(
    .NUM_W (NORM_W),
    .DEN_W (DEN_W),
    .Q_W   (QUO_W),
    .LANES (6),
    .TAG_W ($bits(unit_tag_t))
  ) u_unit_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (gv),
    .in_num    (gnum),
    .in_den    (gden),
    .in_tag    (gtag),
    .out_valid (uv_valid),
    .out_quo   (uquo),
    .out_tag   (utag)
  );

  // ---------------- cross, dot and sine ----------------
  logic                  h1v;
  logic signed [U_W-1:0] pq1 [6];
  logic                  h1deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      h1v <= 1'b0;
    end else begin
      h1v <= uv_valid;
    end
    for (int i = 0; i < 6; i++) begin
      pq1[i] <= utag.neg[i] ? -$signed({1'b0, uquo[i]}) : $signed({1'b0, uquo[i]});
    end
    h1deg <= utag.degen;
  end

  logic                    h2v;
  logic signed [2*U_W-1:0] pr2 [9];
  logic                    h2deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      h2v <= 1'b0;
    end else begin
      h2v <= h1v;
    end
    pr2[0] <= pq1[1] * pq1[5];
    pr2[1] <= pq1[2] * pq1[4];
    pr2[2] <= pq1[2] * pq1[3];
    pr2[3] <= pq1[0] * pq1[5];
    pr2[4] <= pq1[0] * pq1[4];
    pr2[5] <= pq1[1] * pq1[3];
    pr2[6] <= pq1[0] * pq1[3];
    pr2[7] <= pq1[1] * pq1[4];
    pr2[8] <= pq1[2] * pq1[5];
    h2deg  <= h1deg;
  end

  logic h3v;
  acc_t cs3 [3];
  acc_t ds3;
  logic h3deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      h3v <= 1'b0;
    end else begin
      h3v <= h2v;
    end
    cs3[0] <= acc_t'(pr2[0]) - acc_t'(pr2[1]);
    cs3[1] <= acc_t'(pr2[2]) - acc_t'(pr2[3]);
    cs3[2] <= acc_t'(pr2[4]) - acc_t'(pr2[5]);
    ds3    <= acc_t'(pr2[6]) + acc_t'(pr2[7]) + acc_t'(pr2[8]);
    h3deg  <= h2deg;
  end

  logic                  h4v;
  logic signed [C_W-1:0] c4 [3];
  logic signed [C_W-1:0] d4;
  logic                  h4deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      h4v <= 1'b0;
    end else begin
      h4v <= h3v;
    end
    for (int i = 0; i < 3; i++) begin
      c4[i] <= C_W'(rnd_shift(cs3[i], ONE_SH));
    end
    d4    <= C_W'(rnd_shift(ds3, ONE_SH));
    h4deg <= h3deg;
  end

  logic                  h5v;
  logic [MAG_W-1:0]      cm5 [3];
  logic [2:0]            cn5;
  logic signed [U_W-1:0] d5;
  logic                  h5deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      h5v <= 1'b0;
    end else begin
      h5v <= h4v;
    end
    for (int i = 0; i < 3; i++) begin
      cm5[i] <= MAG_W'(abs_acc(acc_t'(c4[i])));
      cn5[i] <= c4[i][C_W-1];
    end
    if (d4 > ONE_C) begin
      d5 <= U_W'(ONE_C);
    end else if (d4 < NONE_C) begin
      d5 <= U_W'(NONE_C);
    end else begin
      d5 <= U_W'(d4);
    end
    h5deg <= h4deg;
  end

  logic              h6v;
  logic [NORM_W-1:0] csq6 [3];
  cross_tag_t        ct6;

  always_ff @(posedge clk) begin
    if (rst) begin
      h6v <= 1'b0;
    end else begin
      h6v <= h5v;
    end
    for (int i = 0; i < 3; i++) begin
      csq6[i]     <= cm5[i] * cm5[i];
      ct6.cmag[i] <= cm5[i];
    end
    ct6.cneg  <= cn5;
    ct6.d     <= d5;
    ct6.degen <= h5deg;
  end

  logic                   h7v;
  logic [0:0][NORM_W-1:0] csum7;
  cross_tag_t             ct7;

  always_ff @(posedge clk) begin
    if (rst) begin
      h7v <= 1'b0;
    end else begin
      h7v <= h6v;
    end
    csum7[0] <= csq6[0] + csq6[1] + csq6[2];
    ct7      <= ct6;
  end

  logic                   sv;
  logic [0:0][ROOT_W-1:0] sroot;
  cross_tag_t             stag;

  rbtv_sqrt #(
    .W     (NORM_W),
    .LANES (1),
    .TAG_W ($bits(cross_tag_t))
  ) u_sine_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h7v),
    .in_rad    (csum7),
    .in_tag    (ct7),
    .out_valid (sv),
    .out_root  (sroot),
    .out_tag   (stag)
  );

  // Axis: round(c * 2^30 / sin); a zero sine marks the word degenerate.
  logic                  iv;
  logic [2:0][NORM_W-1:0] inum;
  logic [2:0][DEN_W-1:0] iden;
  axis_tag_t             itag;
  logic signed [C_W-1:0] kc;

  assign kc = ONE_C - C_W'(stag.d);

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else begin
      iv <= sv;
    end
    for (int i = 0; i < 3; i++) begin
      inum[i] <= (NORM_W'(stag.cmag[i]) << (ONE_SH + 1)) + NORM_W'(sroot[0]);
      iden[i] <= {sroot[0], 1'b0};
    end
    itag.cneg  <= stag.cneg;
    itag.s     <= sroot[0];
    itag.k     <= ROOT_W'(kc);
    itag.d     <= stag.d;
    itag.degen <= stag.degen || (sroot[0] == '0);
  end

  logic                  av;
  logic [2:0][QUO_W-1:0] aquo;
  axis_tag_t             atag;

  rbtv_div #(
    .NUM_W (NORM_W),
    .DEN_W (DEN_W),
    .Q_W   (QUO_W),
    .LANES (3),
    .TAG_W ($bits(axis_tag_t))
  ) u_axis_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (iv),
    .in_num    (inum),
    .in_den    (iden),
    .in_tag    (itag),
    .out_valid (av),
    .out_quo   (aquo),
    .out_tag   (atag)
  );

  // ---------------- matrix assembly ----------------
  logic                  j1v;
  logic signed [U_W-1:0] u1 [3];
  axis_tag_t             jt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      j1v <= 1'b0;
    end else begin
      j1v <= av;
    end
    for (int i = 0; i < 3; i++) begin
      u1[i] <= atag.cneg[i] ? -$signed({1'b0, aquo[i]}) : $signed({1'b0, aquo[i]});
    end
    jt1 <= atag;
  end

  logic                    j2v;
  logic signed [2*U_W-1:0] su2 [3];
  logic signed [2*U_W-1:0] uu2 [9];
  axis_tag_t               jt2;
  logic signed [U_W-1:0]   s1;

  assign s1 = $signed({1'b0, jt1.s});

  always_ff @(posedge clk) begin
    if (rst) begin
      j2v <= 1'b0;
    end else begin
      j2v <= j1v;
    end
    for (int i = 0; i < 3; i++) begin
      su2[i] <= s1 * u1[i];
      for (int j = 0; j < 3; j++) begin
        uu2[i*3+j] <= u1[i] * u1[j];
      end
    end
    jt2 <= jt1;
  end

  logic                  j3v;
  logic signed [C_W-1:0] su3 [3];
  logic signed [C_W-1:0] uu3 [9];
  axis_tag_t             jt3;

  always_ff @(posedge clk) begin
    if (rst) begin
      j3v <= 1'b0;
    end else begin
      j3v <= j2v;
    end
    for (int i = 0; i < 3; i++) begin
      su3[i] <= C_W'(rnd_shift(acc_t'(su2[i]), ONE_SH));
    end
    for (int i = 0; i < 9; i++) begin
      uu3[i] <= C_W'(rnd_shift(acc_t'(uu2[i]), ONE_SH));
    end
    jt3 <= jt2;
  end

  logic                      j4v;
  logic signed [C_W+U_W-1:0] t4  [9];
  logic signed [C_W-1:0]     su4 [3];
  axis_tag_t                 jt4;
  logic signed [U_W-1:0]     k3;

  assign k3 = $signed({1'b0, jt3.k});

  always_ff @(posedge clk) begin
    if (rst) begin
      j4v <= 1'b0;
    end else begin
      j4v <= j3v;
    end
    for (int i = 0; i < 9; i++) begin
      t4[i] <= uu3[i] * k3;
    end
    su4 <= su3;
    jt4 <= jt3;
  end

  logic                  j5v;
  logic signed [C_W-1:0] t5  [9];
  logic signed [C_W-1:0] su5 [3];
  axis_tag_t             jt5;

  always_ff @(posedge clk) begin
    if (rst) begin
      j5v <= 1'b0;
    end else begin
      j5v <= j4v;
    end
    for (int i = 0; i < 9; i++) begin
      t5[i] <= C_W'(rnd_shift(acc_t'(t4[i]), ONE_SH));
    end
    su5 <= su4;
    jt5 <= jt4;
  end

  // Skew-symmetric sine terms; entry [0][1] takes minus the z term.
  logic signed [R_W-1:0] base6 [9];
  logic signed [R_W-1:0] skew6 [9];
  logic                  j6v;
  logic signed [R_W-1:0] r6 [9];
  logic                  deg6;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      base6[i] = R_W'(t5[i]);
      skew6[i] = '0;
    end
    base6[0] = R_W'(t5[0]) + R_W'(jt5.d);
    base6[4] = R_W'(t5[4]) + R_W'(jt5.d);
    base6[8] = R_W'(t5[8]) + R_W'(jt5.d);
    skew6[1] = -R_W'(su5[2]);
    skew6[2] = R_W'(su5[1]);
    skew6[3] = R_W'(su5[2]);
    skew6[5] = -R_W'(su5[0]);
    skew6[6] = -R_W'(su5[1]);
    skew6[7] = R_W'(su5[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j6v <= 1'b0;
    end else begin
      j6v <= j5v;
    end
    for (int i = 0; i < 9; i++) begin
      r6[i] <= base6[i] + skew6[i];
    end
    deg6 <= jt5.degen;
  end

  acc_t                    rr7 [9];
  acc_t                    lim7;
  logic signed [OUT_W-1:0] sat7 [9];
  logic signed [OUT_W-1:0] mo [9];

  always_comb begin
    lim7 = acc_t'(1) <<< FRAC_BITS;
    for (int i = 0; i < 9; i++) begin
      rr7[i] = rnd_shift(acc_t'(r6[i]), OUT_SH);
      if (rr7[i] > lim7) begin
        sat7[i] = ID_OUT;
      end else if (rr7[i] < -lim7) begin
        sat7[i] = NID_OUT;
      end else begin
        sat7[i] = OUT_W'(rr7[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= j6v;
    end
    for (int i = 0; i < 9; i++) begin
      if (deg6) begin
        mo[i] <= (i % 4 == 0) ? ID_OUT : '0;
      end else begin
        mo[i] <= sat7[i];
      end
    end
    degenerate <= deg6;
  end

  assign m00 = mo[0];
  assign m01 = mo[1];
  assign m02 = mo[2];
  assign m10 = mo[3];
  assign m11 = mo[4];
  assign m12 = mo[5];
  assign m20 = mo[6];
  assign m21 = mo[7];
  assign m22 = mo[8];

  `RBTV_ASSERT_IMP(a_degen_identity, done && degenerate, m00 == ID_OUT && m11 == ID_OUT && m22 == ID_OUT && m01 == '0 && m02 == '0 && m10 == '0 && m12 == '0 && m20 == '0 && m21 == '0, "degenerate word is not the identity")
  `RBTV_ASSERT_IMP(a_entry_range, done, m01 <= ID_OUT && m01 >= NID_OUT && m10 <= ID_OUT && m10 >= NID_OUT && m22 <= ID_OUT && m22 >= NID_OUT, "matrix entry beyond one")
  `RBTV_ASSERT_IMP(a_norms_nonzero, nv && !ntag.degen, nroot[0] != '0 && nroot[1] != '0, "zero norm on a valid pair")
  `RBTV_ASSERT_IMP(a_axis_sine, av && !atag.degen, atag.s != '0, "zero sine reached the axis stage")
  `RBTV_ASSERT_NXT(a_sum_to_done, j6v, done, "summed word was not strobed")

endmodule
